// ===== rtl/qrn_pkg.sv =====
// Shared types and constants for the QR numeric-mode segment encoder.
// No dependencies; every rtl file refers to it by scoped names.
package qrn_pkg;

    localparam int MAX_DIGITS_DEF    = 41;
    localparam int CAPACITY_BITS_DEF = 152;
    localparam int COUNT_BITS        = 10;
    localparam int CMD_DEPTH         = 4;

    localparam logic [3:0] MODE_NUMERIC = 4'b0001;
    localparam logic       KIND_START   = 1'b0;
    localparam logic       KIND_DIGIT   = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [5:0] digit_count;
        logic [3:0] digit;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic       error;
    } t_out_item;

    // One bit chunk handed from the front to the back.
    typedef struct packed {
        logic        is_err;
        logic        is_start;
        logic        is_final;
        logic [4:0]  nbits;
        logic [13:0] bits;
    } t_cmd;

endpackage

// ===== rtl/qrn_front.sv =====
// Front part: accepts items, gathers digit groups and forms bit chunks.
// Depends on qrn_pkg.
module qrn_front #(
    parameter int MAX_DIGITS    = qrn_pkg::MAX_DIGITS_DEF,
    parameter int CAPACITY_BITS = qrn_pkg::CAPACITY_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  qrn_pkg::t_in_item i_item,
    output logic             o_cmd_valid,
    output qrn_pkg::t_cmd    o_cmd
);

    localparam logic [5:0] MAX6 = 6'(MAX_DIGITS);
    localparam logic [7:0] CAP8 = 8'(CAPACITY_BITS);

    logic       r_active;
    logic [9:0] r_group_value;
    logic [1:0] r_group_digits;
    logic [5:0] r_digits_left;
    logic [7:0] r_bits_written;

    logic        n_active;
    logic [9:0]  n_group_value;
    logic [1:0]  n_group_digits;
    logic [5:0]  n_digits_left;
    logic [7:0]  n_bits_written;

    logic [3:0]  dig;
    logic [13:0] prod;
    logic [9:0]  gv_sum;
    logic [1:0]  gd_sum;
    logic [5:0]  dl_sum;
    logic [4:0]  grp_bits;
    logic [7:0]  bw_sum;
    logic [7:0]  room;
    logic [2:0]  zeros;
    logic        flush;
    logic        finish;
    logic        bad_count;

    always_comb begin
        dig      = (i_item.digit > 4'd9) ? 4'd9 : i_item.digit;
        prod     = {4'b0, r_group_value} * 14'd10 + {10'b0, dig};
        gv_sum   = prod[9:0];
        gd_sum   = r_group_digits + 2'd1;
        dl_sum   = r_digits_left - 6'd1;
        flush    = (gd_sum == 2'd3) || (dl_sum == 6'd0);
        finish   = (dl_sum == 6'd0);
        grp_bits = (gd_sum == 2'd3) ? 5'd10 : (gd_sum == 2'd2) ? 5'd7 : 5'd4;
        bw_sum   = r_bits_written + {3'b0, grp_bits};
        room     = CAP8 - bw_sum;
        zeros    = 3'd0;
        if (finish && bw_sum < CAP8) begin
            zeros = (room > 8'd4) ? 3'd4 : room[2:0];
        end
        bad_count = (i_item.digit_count == 6'd0) || (i_item.digit_count > MAX6);

        n_active       = r_active;
        n_group_value  = r_group_value;
        n_group_digits = r_group_digits;
        n_digits_left  = r_digits_left;
        n_bits_written = r_bits_written;
        o_cmd_valid    = 1'b0;
        o_cmd          = '0;

        if (i_accept) begin
            unique case (i_item.kind)
                qrn_pkg::KIND_START: begin
                    // A start always aborts any open message; it opens a fresh one only if its count is valid.
                    n_group_value  = '0;
                    n_group_digits = '0;
                    o_cmd_valid    = 1'b1;
                    if (bad_count) begin
                        n_active       = 1'b0;
                        n_digits_left  = '0;
                        n_bits_written = '0;
                        o_cmd.is_err   = 1'b1;
                    end else begin
                        n_active       = 1'b1;
                        n_digits_left  = i_item.digit_count;
                        n_bits_written = 8'(4 + qrn_pkg::COUNT_BITS);
                        o_cmd.is_start = 1'b1;
                        o_cmd.nbits    = 5'(4 + qrn_pkg::COUNT_BITS);
                        o_cmd.bits     = {qrn_pkg::MODE_NUMERIC, 4'b0, i_item.digit_count};
                    end
                end
                qrn_pkg::KIND_DIGIT: begin
                    if (r_active) begin
                        n_group_value  = gv_sum;
                        n_group_digits = gd_sum;
                        n_digits_left  = dl_sum;
                        if (flush) begin
                            o_cmd_valid    = 1'b1;
                            o_cmd.is_final = finish;
                            o_cmd.nbits    = grp_bits + {2'b0, zeros};
                            o_cmd.bits     = {4'b0, gv_sum} << zeros;
                            n_group_value  = '0;
                            n_group_digits = '0;
                            n_bits_written = bw_sum;
                        end
                        if (finish) begin
                            n_active       = 1'b0;
                            n_bits_written = '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_group_value  <= '0;
            r_group_digits <= '0;
            r_digits_left  <= '0;
            r_bits_written <= '0;
        end else begin
            r_active       <= n_active;
            r_group_value  <= n_group_value;
            r_group_digits <= n_group_digits;
            r_digits_left  <= n_digits_left;
            r_bits_written <= n_bits_written;
        end
    end

endmodule

// ===== rtl/qrn_cmd_fifo.sv =====
// Short command queue between the front and the back part.
// Depends on qrn_pkg for the command type and depth.
module qrn_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  qrn_pkg::t_cmd i_data,
    input  logic          i_rd,
    output qrn_pkg::t_cmd o_data,
    output logic          o_full,
    output logic          o_empty
);

    localparam int AW = $clog2(qrn_pkg::CMD_DEPTH);

    qrn_pkg::t_cmd r_mem [qrn_pkg::CMD_DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW:0]   r_count;

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_count == (AW+1)'(qrn_pkg::CMD_DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (AW+1)'(i_wr) - (AW+1)'(i_rd);
        end
    end

endmodule

// ===== rtl/qrn_back.sv =====
// Back part: appends bit chunks to the pending bits and hands out bytes.
// Depends on qrn_pkg.
module qrn_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  qrn_pkg::t_cmd     i_cmd,
    output logic              o_cmd_take,
    output logic              o_empty,
    input  logic              i_pop,
    output qrn_pkg::t_out_item o_result
);

    logic [6:0]  r_pend_v;
    logic [2:0]  r_pend_c;
    logic [23:0] r_stage;
    logic [1:0]  r_nbytes;
    logic        r_final;
    logic        r_err;

    logic        pop_ok;
    logic [6:0]  pend_v;
    logic [2:0]  pend_c;
    logic [20:0] val;
    logic [4:0]  tot;
    logic [4:0]  tot_up;
    logic [4:0]  sh;
    logic [23:0] win;
    logic [2:0]  new_pc;

    always_comb begin
        pop_ok     = i_pop && (r_nbytes != 2'd0);
        o_cmd_take = i_cmd_valid && ((r_nbytes == 2'd0) || (r_nbytes == 2'd1 && pop_ok));
        pend_v     = i_cmd.is_start ? 7'd0 : r_pend_v;
        pend_c     = i_cmd.is_start ? 3'd0 : r_pend_c;
        val        = ({14'b0, pend_v} << i_cmd.nbits) | {7'b0, i_cmd.bits};
        tot        = {2'b0, pend_c} + i_cmd.nbits;
        tot_up     = tot + 5'd7;
        sh         = 5'd24 - tot;
        win        = {3'b0, val} << sh;
        new_pc     = i_cmd.is_final ? 3'd0 : tot[2:0];
        o_empty    = (r_nbytes == 2'd0);
        o_result.out_byte = r_stage[23:16];
        o_result.last     = r_final && (r_nbytes == 2'd1);
        o_result.error    = r_err;
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            if (i_cmd.is_err) begin
                r_stage <= '0;
            end else begin
                r_stage <= win;
            end
            r_final <= i_cmd.is_final || i_cmd.is_err;
            r_err   <= i_cmd.is_err;
        end else if (pop_ok) begin
            r_stage <= {r_stage[15:0], 8'b0};
        end
        if (!i_rst_n) begin
            r_nbytes <= '0;
            r_pend_v <= '0;
            r_pend_c <= '0;
        end else if (o_cmd_take) begin
            if (i_cmd.is_err) begin
                r_nbytes <= 2'd1;
                r_pend_v <= '0;
                r_pend_c <= '0;
            end else begin
                r_nbytes <= i_cmd.is_final ? tot_up[4:3] : tot[4:3];
                r_pend_v <= val[6:0] & ((7'd1 << new_pc) - 7'd1);
                r_pend_c <= new_pc;
            end
        end else if (pop_ok) begin
            r_nbytes <= r_nbytes - 2'd1;
        end
    end

endmodule

// ===== rtl/qr_numeric_segment_encoder.sv =====
// When the queue and the byte stage are empty, an accepted transaction's command is written
// into the command queue, then loaded into the byte stage, before its first byte shows.
// Throughput: one input transaction per cycle while the command queue has room; results
// leave at one byte per cycle while ready and popped, set by the single result stage.
// Reset: synchronous, active low; clears the open message, the queue and the byte stage.
// Top level: QR numeric-mode data bitstream encoder for a version-1 symbol.
// Depends on qrn_pkg, qrn_front, qrn_cmd_fifo and qrn_back.
module qr_numeric_segment_encoder #(
    parameter int MAX_DIGITS    = qrn_pkg::MAX_DIGITS_DEF,
    parameter int CAPACITY_BITS = qrn_pkg::CAPACITY_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  qrn_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output qrn_pkg::t_out_item o_result
);

    // The front part tracks the message: the digits still expected, the digit
    // group being gathered and how many stream bits the message holds so far.
    // Every transaction that produces stream bits becomes one command: the mode
    // and count header on a start, a packed group (with terminator zeros on the
    // last one) on a flushing digit, or an error marker on a bad count.
    // Digits that only grow a group produce no command at all.

    logic          accept;
    logic          f_valid;
    qrn_pkg::t_cmd f_cmd;
    qrn_pkg::t_cmd q_cmd;
    logic          q_empty;
    logic          b_take;

    assign accept = push && !full;

    qrn_front #(
        .MAX_DIGITS   (MAX_DIGITS),
        .CAPACITY_BITS(CAPACITY_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .o_cmd_valid(f_valid),
        .o_cmd      (f_cmd)
    );

    // The queue lets the front keep taking digits while the back part is
    // still handing out the bytes of an earlier command.
    qrn_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (f_valid),
        .i_data (f_cmd),
        .i_rd   (b_take),
        .o_data (q_cmd),
        .o_full (full),
        .o_empty(q_empty)
    );

    // The back part keeps the up to seven bits that do not yet fill a byte.
    // It joins them with each command into at most three bytes, which it
    // presents one at a time from a registered stage; the next command loads
    // in the same cycle as the last of those bytes is popped.
    qrn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(!q_empty),
        .i_cmd      (q_cmd),
        .o_cmd_take (b_take),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_result   (o_result)
    );

endmodule

// ===== rtl/qrn_checker.sv =====
// Port-level checks for the QR numeric-mode segment encoder, with its bind.
// Depends on qrn_pkg and the top level qr_numeric_segment_encoder.
module qrn_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input qrn_pkg::t_out_item o_result
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result side not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk)
        !i_rst_n |=> !full)
        else $error("input side full after reset");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.error) |-> o_result.last)
        else $error("error result without last marker");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.error) |-> (o_result.out_byte == 8'd0))
        else $error("error result carries a nonzero byte");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed before it was popped");

endmodule

bind qr_numeric_segment_encoder qrn_checker u_qrn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_result(o_result)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for qr_numeric_segment_encoder, a QR numeric-mode bitstream builder.
// Depends on qrn_pkg for the item types and constants, and on the encoder RTL itself.
module tb_top;
    import qrn_pkg::*;

    localparam real HALF_PERIOD    = 2.0;
    localparam int  MAX_GAP        = 18;
    localparam int  RANDOM_ITEMS   = 40;
    localparam int  WATCHDOG_LIMIT = 500;
    localparam int  TAIL_CYCLES    = 20;
    localparam int  SHOW_LIMIT     = 10;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      push    = 1'b0;
    logic      full;
    t_in_item  i_item  = '0;
    logic      empty;
    logic      pop     = 1'b0;
    t_out_item o_result;

    qr_numeric_segment_encoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Run bookkeeping.
    bit rst_done   = 1'b0;
    bit idle_on    = 1'b1;
    bit rx_idle    = 1'b1;
    int rx_hold    = 0;
    int items_sent = 0;
    int bytes_seen = 0;
    int msgs_ended = 0;
    int bad_starts = 0;
    int errors     = 0;
    int quiet      = 0;

    // Encoder mirror: the bits waiting to fill a byte, the digit group being
    // gathered, and the progress through the open message.
    logic [7:0]  acc_bits;
    int unsigned acc_cnt;
    int unsigned grp_val;
    int unsigned grp_cnt;
    int unsigned left_digits;
    int unsigned bits_done;
    bit          msg_open;

    // Bytes produced by the item being encoded, then the stream of bytes that
    // the block still owes us, oldest first.
    t_out_item step_out [3];
    int        step_n;
    t_out_item coded_bytes_q [$];

    function void clear_encoder();
        acc_bits    = '0;
        acc_cnt     = 0;
        grp_val     = 0;
        grp_cnt     = 0;
        left_digits = 0;
        bits_done   = 0;
        msg_open    = 1'b0;
    endfunction

    function void emit_byte(logic [7:0] b, logic lst, logic err);
        t_out_item r;
        r.out_byte = b;
        r.last     = lst;
        r.error    = err;
        if (step_n < 3) begin
            step_out[step_n] = r;
            step_n++;
        end
    endfunction

    // Appends the n low bits of value to the stream, most significant first,
    // and hands off every byte as soon as it is complete.
    function void shift_in_bits(int unsigned value, int unsigned n);
        logic b;
        for (int i = n; i > 0; i--) begin
            b        = 1'((value >> (i - 1)) & 1);
            acc_bits = {acc_bits[6:0], b};
            acc_cnt++;
            if (bits_done < 255) begin
                bits_done++;
            end
            if (acc_cnt == 8) begin
                emit_byte(acc_bits, 1'b0, 1'b0);
                acc_bits = '0;
                acc_cnt  = 0;
            end
        end
        acc_bits[7] = 1'b0;
    endfunction

    // Works out the bytes that one accepted item causes and queues them.
    function void encode_item(t_in_item it);
        int unsigned d;
        int unsigned n;
        int unsigned zeros;
        step_n = 0;
        if (it.kind == KIND_START) begin
            // A start always discards whatever message was open.
            clear_encoder();
            if (it.digit_count == 0 || it.digit_count > MAX_DIGITS_DEF) begin
                emit_byte(8'h00, 1'b1, 1'b1);
            end else begin
                msg_open    = 1'b1;
                left_digits = it.digit_count;
                shift_in_bits(MODE_NUMERIC, 4);
                shift_in_bits(it.digit_count, COUNT_BITS);
            end
        end else if (msg_open) begin
            d       = (it.digit > 9) ? 9 : it.digit;
            grp_val = (grp_val * 10 + d) & 'h3FF;
            grp_cnt++;
            left_digits--;
            if (grp_cnt == 3 || left_digits == 0) begin
                n = (grp_cnt == 3) ? 10 : (grp_cnt == 2) ? 7 : 4;
                shift_in_bits(grp_val, n);
                grp_val = 0;
                grp_cnt = 0;
            end
            if (left_digits == 0) begin
                // Terminator of up to four zeros, cut short at the symbol
                // capacity, then zero fill to the next byte boundary.
                zeros = 0;
                if (bits_done < CAPACITY_BITS_DEF) begin
                    zeros = CAPACITY_BITS_DEF - bits_done;
                    if (zeros > 4) begin
                        zeros = 4;
                    end
                end
                shift_in_bits(0, zeros);
                while (acc_cnt != 0) begin
                    shift_in_bits(0, 1);
                end
                if (step_n > 0) begin
                    step_out[step_n - 1].last = 1'b1;
                end
                clear_encoder();
            end
        end
        for (int k = 0; k < step_n; k++) begin
            coded_bytes_q.insert(coded_bytes_q.size(), step_out[k]);
        end
    endfunction

    function void note_error(string msg);
        errors++;
        if (errors <= SHOW_LIMIT) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endfunction

    // Drives one item at a falling edge after a random pause, holds it until
    // a rising edge accepts the transaction, and then predicts its bytes.
    task automatic send_item(t_in_item it);
        int gap;
        gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        encode_item(it);
        items_sent++;
    endtask

    // The field that an item kind does not use is filled at random, so every
    // bit of every field moves.
    function t_in_item make_start(int count);
        t_in_item it;
        it.kind        = KIND_START;
        it.digit_count = 6'(count);
        it.digit       = 4'($urandom_range(0, 15));
        return it;
    endfunction

    function t_in_item make_digit(int d);
        t_in_item it;
        it.kind        = KIND_DIGIT;
        it.digit_count = 6'($urandom_range(0, 63));
        it.digit       = 4'(d);
        return it;
    endfunction

    // A start with the given count followed by n random digits; now and then
    // a digit is above nine to exercise the clamp.
    task automatic send_message(int count, int n);
        send_item(make_start(count));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_item(make_digit($urandom_range(10, 15)));
            end else begin
                send_item(make_digit($urandom_range(0, 9)));
            end
        end
    endtask

    // Holds the sender back until the block has delivered every byte owed.
    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (coded_bytes_q.size() != 0) @(posedge i_clk);
    endtask

    // Counts of zero, the largest field value and one above the digit limit
    // all end in a single error byte; a digit with no open message is dropped.
    task automatic test_bad_counts();
        send_item(make_start(0));
        send_item(make_start(63));
        send_item(make_start(MAX_DIGITS_DEF + 1));
        send_item(make_digit(15));
        wait_drained();
    endtask

    // One, two, three and four digit messages cover every short group length;
    // the three digit one carries values above nine.
    task automatic test_short_messages();
        send_item(make_start(1));
        send_item(make_digit(0));
        send_item(make_start(2));
        send_item(make_digit(9));
        send_item(make_digit(9));
        send_item(make_start(3));
        send_item(make_digit(15));
        send_item(make_digit(12));
        send_item(make_digit(0));
        send_item(make_start(4));
        for (int i = 1; i <= 4; i++) begin
            send_item(make_digit(i));
        end
        wait_drained();
    endtask

    // A start in the middle of a message throws the partial message away.
    task automatic test_abort();
        send_item(make_start(5));
        send_item(make_digit(7));
        send_item(make_digit(8));
        send_item(make_start(1));
        send_item(make_digit(5));
        wait_drained();
    endtask

    // The longest message leaves room for only one terminator zero.
    task automatic test_capacity();
        send_item(make_start(MAX_DIGITS_DEF));
        repeat (MAX_DIGITS_DEF) send_item(make_digit(9));
        wait_drained();
    endtask

    // Mostly complete messages of random length and content, mixed with cut
    // off messages, bad counts and stray digits.
    task automatic test_random();
        int first;
        int pick;
        int cnt;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                idle_on = ~idle_on;
            end
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_DIGITS_DEF)
                                                  : $urandom_range(1, 12);
                send_message(cnt, cnt);
            end else if (pick < 84) begin
                cnt = $urandom_range(2, 12);
                send_message(cnt, $urandom_range(0, cnt - 1));
            end else if (pick < 92) begin
                cnt = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_DIGITS_DEF + 1, 63);
                send_item(make_start(cnt));
            end else begin
                repeat ($urandom_range(1, 3)) send_item(make_digit($urandom_range(0, 15)));
            end
            if ($urandom_range(0, 15) == 0) begin
                wait_drained();
            end
        end
        idle_on = 1'b1;
        wait_drained();
    endtask

    // Result side: at each rising edge an accepted transaction is checked
    // against the oldest predicted byte; at each falling edge pop is driven
    // from a random hold that is drawn anew for every result.
    always begin : rx_side
        t_out_item want;
        @(posedge i_clk);
        if (rst_done && pop && !empty) begin
            bytes_seen++;
            if (coded_bytes_q.size() == 0) begin
                note_error($sformatf("unexpected byte %02h last %0b error %0b",
                                     o_result.out_byte, o_result.last, o_result.error));
            end else begin
                want = coded_bytes_q.pop_front();
                if (o_result.out_byte !== want.out_byte || o_result.last !== want.last
                    || o_result.error !== want.error) begin
                    note_error($sformatf(
                        "byte %0d: expected %02h/%0b/%0b got %02h/%0b/%0b (byte/last/error)",
                        bytes_seen, want.out_byte, want.last, want.error,
                        o_result.out_byte, o_result.last, o_result.error));
                end
                if (want.last && !want.error) begin
                    msgs_ended++;
                end
                if (want.error) begin
                    bad_starts++;
                end
            end
            rx_hold = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
            if ($urandom_range(0, 15) == 0) begin
                rx_idle = ~rx_idle;
            end
        end
        @(negedge i_clk);
        if (rx_hold > 0) begin
            pop <= 1'b0;
            rx_hold--;
        end else begin
            pop <= 1'b1;
        end
    end

    // Watchdog: a long run of cycles without any transaction means the block
    // has hung or has lost bytes.
    always @(posedge i_clk) begin
        if (!rst_done || (push && !full) || (pop && !empty)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no transaction for %0d cycles, %0d bytes owed",
                         $realtime, quiet, coded_bytes_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        clear_encoder();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1'b1;

        test_bad_counts();
        test_short_messages();
        test_abort();
        test_capacity();
        test_random();

        // Everything owed has arrived; give the block time to show any
        // stray byte before closing the run.
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items; checked %0d bytes, %0d complete messages, %0d error results.",
                 items_sent, bytes_seen, msgs_ended, bad_starts);
        $display("Mismatches or stray bytes: %0d.", errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
